FILE: src/nhlc_pkg.sv
// Package for the next-hop loop checker: item and command types, opcode and status codes.
// Used by every module of the block; it depends on nothing else.
package nhlc_pkg;

    localparam int NODE_W        = 6;
    localparam int NODE_SPAN     = 64;
    localparam int HOPS_W        = 7;
    localparam int STATUS_W      = 3;
    localparam int OPCODE_W      = 2;
    localparam int ENTRY_W       = 8;
    localparam int NODES_DEFAULT = 64;
    localparam int QUEUE_DEPTH   = 2;

    // Route entry layout: present flag, next-hop flag, next hop.
    localparam int ENT_PRESENT_BIT = 7;
    localparam int ENT_HAS_HOP_BIT = 6;

    localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_FLAG = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_WRITE_DONE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELIVERED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOOP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_HOP     = 3'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   destination;
        logic [NODE_W-1:0]   next_hop;
        logic                has_next_hop;
        logic                table_present;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_loop;
        logic [HOPS_W-1:0]   hops;
        logic [NODE_W-1:0]   stop_node;
    } out_item_t;

    // Classified command handed from the front end to the walker.
    typedef struct packed {
        logic [OPCODE_W-1:0] kind;
        logic                node_ok;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   destination;
        logic [ENTRY_W-1:0]  entry;
        logic                table_present;
    } cmd_t;

endpackage

FILE: src/next_hop_loop_checker.sv
// Next-hop loop checker: per-node route tables, with a walker that follows next hops.
// Throughput: one write item per cycle while the result register is free; a query holds the
// walker until its walk ends. Reset: synchronous, active low; it then clears the route memory
// one entry a cycle, executing no item meanwhile.
module next_hop_loop_checker #(
    parameter int NODES = nhlc_pkg::NODES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nhlc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output nhlc_pkg::out_item_t m_item
);
    import nhlc_pkg::*;

    // The front end only decodes; every accepted item goes straight into the queue, so
    // the input side moves while the walker is busy or a result waits, until the queue fills.
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic q_full;
    logic head_valid;
    logic head_pop;

    nhlc_front #(
        .NODES (NODES)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .push    (front_push),
        .cmd     (front_cmd)
    );

    // The queue parts the two sides, so each can stall on its own.
    nhlc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end owns the tables and the walk; its result register holds a finished
    // item until the consumer takes it, while the queue keeps filling behind it.
    nhlc_back #(
        .NODES (NODES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

FILE: src/nhlc_front.sv
// Front end of the next-hop loop checker: accepts items and classifies them into commands.
// Depends on nhlc_pkg.
module nhlc_front #(
    parameter int NODES = nhlc_pkg::NODES_DEFAULT
) (
    input  logic             s_valid,
    output logic             s_ready,
    input  nhlc_pkg::in_item_t s_item,
    input  logic             q_full,
    output logic             push,
    output nhlc_pkg::cmd_t   cmd
);
    import nhlc_pkg::*;

    localparam int ROWS  = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
    localparam int LIM_W = NODE_W + 1;
    localparam logic [LIM_W-1:0] NODE_LIMIT = LIM_W'(ROWS);

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        cmd.kind          = s_item.opcode;
        cmd.node_ok       = {1'b0, s_item.node} < NODE_LIMIT;
        cmd.node          = s_item.node;
        cmd.destination   = s_item.destination;
        cmd.table_present = s_item.table_present;
        unique case (s_item.opcode) inside
            OP_WRITE: begin
                cmd.entry = {1'b1, s_item.has_next_hop, s_item.next_hop};
            end
            OP_REMOVE, OP_SET_FLAG, OP_QUERY: begin
                cmd.entry = '0;
            end
            default: begin
                cmd.entry = '0;
            end
        endcase
    end

endmodule

FILE: src/nhlc_queue.sv
// Short command queue between the front end and the walker of the next-hop loop checker.
// Depends on nhlc_pkg.
module nhlc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nhlc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output nhlc_pkg::cmd_t head_cmd
);
    import nhlc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/nhlc_back.sv
// Back end of the next-hop loop checker: route memory, table flags, next-hop walker and
// result register. Depends on nhlc_pkg.
module nhlc_back #(
    parameter int NODES = nhlc_pkg::NODES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  nhlc_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output nhlc_pkg::out_item_t m_item
);
    import nhlc_pkg::*;

    localparam int ROWS      = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ADDR_W    = ROW_W + NODE_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int LIM_W     = NODE_W + 1;
    localparam logic [LIM_W-1:0]  NODE_LIMIT = LIM_W'(ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = '1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [ENTRY_W-1:0]   mem [0:MEM_DEPTH-1];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [ROWS-1:0]      table_reg;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [NODE_W-1:0]    cur_reg, cur_next;
    logic [NODE_W-1:0]    dest_reg, dest_next;
    logic [HOPS_W-1:0]    hops_reg, hops_next;
    logic [NODE_SPAN-1:0] visited_reg, visited_next;
    logic                 out_valid_reg;
    out_item_t            out_item_reg, out_item_next;

    logic                 mem_we, rd_en, tab_we, load_out, out_free;
    logic [ADDR_W-1:0]    mem_waddr, rd_addr;
    logic [ENTRY_W-1:0]   mem_wdata;

    logic                 cur_ok, cur_has_table, ent_present, ent_has_hop;
    logic [NODE_W-1:0]    ent_hop;
    logic [HOPS_W-1:0]    hops_inc;

    assign out_free      = !out_valid_reg || m_ready;
    assign cur_ok        = {1'b0, cur_reg} < NODE_LIMIT;
    assign cur_has_table = cur_ok && table_reg[cur_reg[ROW_W-1:0]];
    assign ent_present   = rd_data_reg[ENT_PRESENT_BIT];
    assign ent_has_hop   = rd_data_reg[ENT_HAS_HOP_BIT];
    assign ent_hop       = rd_data_reg[NODE_W-1:0];
    assign hops_inc      = hops_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        dest_next     = dest_reg;
        hops_next     = hops_reg;
        visited_next  = visited_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {cmd.node[ROW_W-1:0], cmd.destination};
        mem_wdata     = cmd.entry;
        tab_we        = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = {cmd.node[ROW_W-1:0], cmd.destination};
        load_out      = 1'b0;
        out_item_next = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.kind == OP_QUERY) begin
                        cmd_pop      = 1'b1;
                        rd_en        = 1'b1;
                        cur_next     = cmd.node;
                        dest_next    = cmd.destination;
                        hops_next    = '0;
                        visited_next = '0;
                        visited_next[cmd.node] = 1'b1;
                        state_next   = S_WALK;
                    end else if (out_free) begin
                        cmd_pop  = 1'b1;
                        load_out = 1'b1;
                        mem_we   = cmd.node_ok &&
                                   (cmd.kind == OP_WRITE || cmd.kind == OP_REMOVE);
                        tab_we   = cmd.node_ok && (cmd.kind == OP_SET_FLAG);
                    end
                end
            end
            S_WALK: begin
                out_item_next.hops      = hops_inc;
                out_item_next.stop_node = ent_hop;
                if (!cur_has_table || !ent_present || !ent_has_hop) begin
                    out_item_next.hops      = hops_reg;
                    out_item_next.stop_node = cur_reg;
                    if (!cur_has_table) begin
                        out_item_next.status = ST_NO_TABLE;
                    end else if (!ent_present) begin
                        out_item_next.status = ST_NO_ENTRY;
                    end else begin
                        out_item_next.status = ST_NO_HOP;
                    end
                    load_out = out_free;
                end else if (ent_hop == dest_reg) begin
                    out_item_next.status = ST_DELIVERED;
                    load_out = out_free;
                end else if (visited_reg[ent_hop]) begin
                    out_item_next.status  = ST_LOOP;
                    out_item_next.is_loop = 1'b1;
                    load_out = out_free;
                end else begin
                    // Follow the hop: fetch the next node's entry for the same destination.
                    rd_en        = 1'b1;
                    rd_addr      = {ent_hop[ROW_W-1:0], dest_reg};
                    cur_next     = ent_hop;
                    hops_next    = hops_inc;
                    visited_next = visited_reg;
                    visited_next[ent_hop] = 1'b1;
                end
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            table_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (tab_we) begin
                table_reg[cmd.node[ROW_W-1:0]] <= cmd.table_present;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        dest_reg    <= dest_next;
        hops_reg    <= hops_next;
        visited_reg <= visited_next;
        if (load_out) begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
